// ===== sv/arpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    // Field widths
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int ENTRY_W = IP_W + MAC_W + TIME_W;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_OUT_W = 2;

    // Operation codes
    localparam logic OP_ENTER = 1'b0;
    localparam logic OP_FIND  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd2;

    // Register reset values
    localparam logic [IP_W-1:0] LOCAL_IP_RST    = 32'hC0A8_500A;
    localparam logic [IP_W-1:0] SUBNET_MASK_RST = 32'hFFFF_FF00;
    localparam logic [IP_W-1:0] GATEWAY_IP_RST  = 32'hC0A8_5001;

    // Status from the shared compare unit to the sequencer
    typedef struct packed {
        logic              match;
        logic              older;
        logic [TIME_W-1:0] age;
    } cmp_status_t;

endpackage

`default_nettype wire

// ===== sv/arpc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/arpc_match_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module arpc_match_unit (
    input  wire logic [arpc_pkg::IP_W-1:0]   key,
    input  wire logic [arpc_pkg::IP_W-1:0]   entry_ip,
    input  wire logic [arpc_pkg::TIME_W-1:0] entry_time,
    input  wire logic [arpc_pkg::TIME_W-1:0] now,
    input  wire logic [arpc_pkg::TIME_W-1:0] best_age,
    output arpc_pkg::cmp_status_t            status
);

    logic [arpc_pkg::TIME_W-1:0] age;

    // Wrapping age, strict compare against the oldest seen so far
    assign age          = now - entry_time;
    assign status.age   = age;
    assign status.older = (age > best_age);
    assign status.match = (entry_ip == key);

endmodule

`default_nettype wire

// ===== sv/arp_cache_lookup_update_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// IPv4-to-MAC cache with ENTRIES slots held in one RAM word per slot (IP, MAC,
// time). Operation 0 enters a mapping into the slot holding the same IP, or
// else the slot with the greatest wrapping age (now_ms - time), slot 0 when all
// ages are zero; operation 1 finds the MAC for an IP and, for an off-subnet
// miss, answers with the slot holding the gateway IP. Slots are scanned one per
// cycle through one compare/age unit behind the RAM's registered read port, and
// a scan stops early on a match; an off-subnet find miss runs a second scan for
// the gateway. s_ready is high only between items. The slots read as zero after
// reset, so a find of IP 0 hits an unused slot. Configuration registers:
// 0 local_ip, 1 subnet_mask, 2 gateway_ip; index 3 is ignored.
module arp_cache_lookup_update_top #(
    parameter int ENTRIES = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_operation,
    input  wire logic [arpc_pkg::IP_W-1:0]         s_ip_addr,
    input  wire logic [arpc_pkg::MAC_W-1:0]        s_mac_addr,
    input  wire logic [arpc_pkg::TIME_W-1:0]       s_now_ms,
    // Result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_hit,
    output logic                                   m_via_gateway,
    output logic      [arpc_pkg::MAC_W-1:0]        m_mac_out,
    output logic      [arpc_pkg::IDX_OUT_W-1:0]    m_entry_index,
    // Configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [arpc_pkg::IP_W-1:0]         cfg_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    // Item registers
    logic                            op_reg, op_next;
    logic [arpc_pkg::IP_W-1:0]       ip_reg, ip_next;
    logic [arpc_pkg::MAC_W-1:0]      mac_reg, mac_next;
    logic [arpc_pkg::TIME_W-1:0]     now_reg, now_next;
    logic [arpc_pkg::IP_W-1:0]       key_reg, key_next;
    logic                            gw_pass_reg, gw_pass_next;

    // Scan pointers
    logic [CW-1:0]                   rd_idx_reg, rd_idx_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic [IW-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic [arpc_pkg::TIME_W-1:0]     best_age_reg, best_age_next;
    logic [IW-1:0]                   best_slot_reg, best_slot_next;

    // Pending result
    logic                            res_hit_reg, res_hit_next;
    logic                            res_via_reg, res_via_next;
    logic [arpc_pkg::MAC_W-1:0]      res_mac_reg, res_mac_next;
    logic [IW-1:0]                   res_slot_reg, res_slot_next;

    // Output register
    logic                            m_valid_reg, m_valid_next;
    logic                            m_hit_reg, m_hit_next;
    logic                            m_via_reg, m_via_next;
    logic [arpc_pkg::MAC_W-1:0]      m_mac_reg, m_mac_next;
    logic [arpc_pkg::IDX_OUT_W-1:0]  m_idx_reg, m_idx_next;

    // Slot valid bits, configuration registers
    logic [ENTRIES-1:0]              valid_reg, valid_next;
    logic [arpc_pkg::IP_W-1:0]       local_ip_reg, local_ip_next;
    logic [arpc_pkg::IP_W-1:0]       mask_reg, mask_next;
    logic [arpc_pkg::IP_W-1:0]       gw_ip_reg, gw_ip_next;

    // RAM and compare unit wiring
    logic                            issue;
    logic                            wr_en;
    logic [arpc_pkg::ENTRY_W-1:0]    rd_data;
    logic [arpc_pkg::ENTRY_W-1:0]    wr_data;
    logic                            ent_valid;
    logic [arpc_pkg::IP_W-1:0]       ent_ip;
    logic [arpc_pkg::MAC_W-1:0]      ent_mac;
    logic [arpc_pkg::TIME_W-1:0]     ent_time;
    arpc_pkg::cmp_status_t           cmp;
    logic                            last_cmp;
    logic                            on_subnet;
    logic                            out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_via_gateway = m_via_reg;
    assign m_mac_out     = m_mac_reg;
    assign m_entry_index = m_idx_reg;

    assign issue    = (state_reg == ST_SCAN) && (rd_idx_reg < CW'(ENTRIES));
    assign out_free = !m_valid_reg || m_ready;
    assign wr_en    = (state_reg == ST_RESP) && out_free && (op_reg == arpc_pkg::OP_ENTER);
    assign wr_data  = {ip_reg, mac_reg, now_reg};

    // Slot storage
    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (res_slot_reg),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    // Never-written slots read as zero
    assign ent_valid = valid_reg[cmp_idx_reg];
    assign ent_ip    = ent_valid ? rd_data[arpc_pkg::ENTRY_W-1 -: arpc_pkg::IP_W] : '0;
    assign ent_mac   = ent_valid ? rd_data[arpc_pkg::TIME_W +: arpc_pkg::MAC_W] : '0;
    assign ent_time  = ent_valid ? rd_data[arpc_pkg::TIME_W-1:0] : '0;

    arpc_match_unit u_cmp (
        .key        (key_reg),
        .entry_ip   (ent_ip),
        .entry_time (ent_time),
        .now        (now_reg),
        .best_age   (best_age_reg),
        .status     (cmp)
    );

    assign last_cmp  = (cmp_idx_reg == IW'(ENTRIES - 1));
    assign on_subnet = ((ip_reg & mask_reg) == (local_ip_reg & mask_reg));

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        ip_next        = ip_reg;
        mac_next       = mac_reg;
        now_next       = now_reg;
        key_next       = key_reg;
        gw_pass_next   = gw_pass_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_age_next  = best_age_reg;
        best_slot_next = best_slot_reg;
        res_hit_next   = res_hit_reg;
        res_via_next   = res_via_reg;
        res_mac_next   = res_mac_reg;
        res_slot_next  = res_slot_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_hit_next     = m_hit_reg;
        m_via_next     = m_via_reg;
        m_mac_next     = m_mac_reg;
        m_idx_next     = m_idx_reg;
        valid_next     = valid_reg;
        local_ip_next  = local_ip_reg;
        mask_next      = mask_reg;
        gw_ip_next     = gw_ip_reg;

        // Configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                arpc_pkg::REG_LOCAL_IP:    local_ip_next = cfg_data;
                arpc_pkg::REG_SUBNET_MASK: mask_next     = cfg_data;
                arpc_pkg::REG_GATEWAY_IP:  gw_ip_next    = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_operation;
                    ip_next        = s_ip_addr;
                    mac_next       = s_mac_addr;
                    now_next       = s_now_ms;
                    key_next       = s_ip_addr;
                    gw_pass_next   = 1'b0;
                    rd_idx_next    = '0;
                    best_age_next  = '0;
                    best_slot_next = '0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Read one slot a cycle
                if (issue) begin
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    cmp_idx_next = rd_idx_reg[IW-1:0];
                    rd_pend_next = 1'b1;
                end
                // Compare the slot read last cycle
                if (rd_pend_reg) begin
                    if (cmp.match) begin
                        res_hit_next  = 1'b1;
                        res_via_next  = gw_pass_reg;
                        res_mac_next  = ent_mac;
                        res_slot_next = cmp_idx_reg;
                        state_next    = ST_RESP;
                    end else begin
                        if (cmp.older) begin
                            best_age_next  = cmp.age;
                            best_slot_next = cmp_idx_reg;
                        end
                        if (last_cmp) begin
                            res_hit_next = 1'b0;
                            res_via_next = 1'b0;
                            res_mac_next = '0;
                            if (op_reg == arpc_pkg::OP_ENTER) begin
                                // Replace the oldest slot
                                res_slot_next = cmp.older ? cmp_idx_reg : best_slot_reg;
                                state_next    = ST_RESP;
                            end else if (!gw_pass_reg && !on_subnet) begin
                                // Off-subnet miss: scan again for the gateway
                                key_next     = gw_ip_reg;
                                gw_pass_next = 1'b1;
                                rd_idx_next  = '0;
                                rd_pend_next = 1'b0;
                            end else begin
                                res_slot_next = '0;
                                state_next    = ST_RESP;
                            end
                        end
                    end
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_via_next   = res_via_reg;
                    m_mac_next   = res_mac_reg;
                    m_idx_next   = arpc_pkg::IDX_OUT_W'(res_slot_reg);
                    if (wr_en) begin
                        valid_next = valid_reg | (ENTRIES'(1) << res_slot_reg);
                    end
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            valid_reg    <= '0;
            local_ip_reg <= arpc_pkg::LOCAL_IP_RST;
            mask_reg     <= arpc_pkg::SUBNET_MASK_RST;
            gw_ip_reg    <= arpc_pkg::GATEWAY_IP_RST;
        end else begin
            state_reg    <= state_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
            valid_reg    <= valid_next;
            local_ip_reg <= local_ip_next;
            mask_reg     <= mask_next;
            gw_ip_reg    <= gw_ip_next;
        end
        op_reg        <= op_next;
        ip_reg        <= ip_next;
        mac_reg       <= mac_next;
        now_reg       <= now_next;
        key_reg       <= key_next;
        gw_pass_reg   <= gw_pass_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_age_reg  <= best_age_next;
        best_slot_reg <= best_slot_next;
        res_hit_reg   <= res_hit_next;
        res_via_reg   <= res_via_next;
        res_mac_reg   <= res_mac_next;
        res_slot_reg  <= res_slot_next;
        m_hit_reg     <= m_hit_next;
        m_via_reg     <= m_via_next;
        m_mac_reg     <= m_mac_next;
        m_idx_reg     <= m_idx_next;
    end

endmodule

`default_nettype wire

// ===== sim/arp_cache_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the ARP cache, keeps its own copy of the
// slots and registers, and checks every result word against the answer
// expected for the oldest accepted input word.
module arp_cache_checker
    import arpc_pkg::*;
#(
    parameter int SLOTS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_operation,
    input  logic [IP_W-1:0]      s_ip_addr,
    input  logic [MAC_W-1:0]     s_mac_addr,
    input  logic [TIME_W-1:0]    s_now_ms,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_hit,
    input  logic                 m_via_gateway,
    input  logic [MAC_W-1:0]     m_mac_out,
    input  logic [IDX_OUT_W-1:0] m_entry_index,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IP_W-1:0]      cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic                 hit;
        logic                 via_gateway;
        logic [MAC_W-1:0]     mac;
        logic [IDX_OUT_W-1:0] index;
    } arp_answer_t;

    // Mirror of the registers and the slot store
    logic [IP_W-1:0]   own_ip;
    logic [IP_W-1:0]   net_mask;
    logic [IP_W-1:0]   gateway;
    logic [IP_W-1:0]   slot_ip   [SLOTS];
    logic [MAC_W-1:0]  slot_mac  [SLOTS];
    logic [TIME_W-1:0] slot_time [SLOTS];

    arp_answer_t expected_answers[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // First slot holding ip, -1 if none
    function automatic int first_slot_with(logic [IP_W-1:0] ip);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_ip[i] == ip) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Answer for one input word; an enter also updates the slot store
    function automatic arp_answer_t resolve_word(logic op, logic [IP_W-1:0] ip,
                                                 logic [MAC_W-1:0] mac,
                                                 logic [TIME_W-1:0] now);
        arp_answer_t       ans;
        int                s;
        logic [TIME_W-1:0] oldest_age;
        logic [TIME_W-1:0] age;
        ans        = '0;
        s          = 0;
        oldest_age = '0;
        if (op == OP_ENTER) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_ip[i] == ip) begin
                    s       = i;
                    ans.hit = 1'b1;
                    ans.mac = slot_mac[i];
                    break;
                end
                // wrapping age, strictly greater so the earliest slot wins ties
                age = now - slot_time[i];
                if (age > oldest_age) begin
                    oldest_age = age;
                    s          = i;
                end
            end
            slot_ip[s]   = ip;
            slot_mac[s]  = mac;
            slot_time[s] = now;
        end else begin
            s = first_slot_with(ip);
            // off-subnet miss falls back to the gateway slot
            if (s < 0 && (ip & net_mask) != (own_ip & net_mask)) begin
                s               = first_slot_with(gateway);
                ans.via_gateway = (s >= 0);
            end
            if (s >= 0) begin
                ans.hit = 1'b1;
                ans.mac = slot_mac[s];
            end else begin
                s = 0;
            end
        end
        ans.index = s[IDX_OUT_W-1:0];
        return ans;
    endfunction

    task automatic compare_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches = mismatches + 1;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
        end
    endtask

    // Channel monitor
    always @(posedge aclk) begin
        arp_answer_t want;
        if (!aresetn) begin
            own_ip   = LOCAL_IP_RST;
            net_mask = SUBNET_MASK_RST;
            gateway  = GATEWAY_IP_RST;
            for (int i = 0; i < SLOTS; i++) begin
                slot_ip[i]   = '0;
                slot_mac[i]  = '0;
                slot_time[i] = '0;
            end
            expected_answers.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LOCAL_IP:    own_ip   = cfg_data;
                    REG_SUBNET_MASK: net_mask = cfg_data;
                    REG_GATEWAY_IP:  gateway  = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: result word with none expected, expected nothing, actual hit=%0b via=%0b mac=0x%0h index=%0d",
                             $time, m_hit, m_via_gateway, m_mac_out, m_entry_index);
                end else begin
                    want = expected_answers.pop_front();
                    compare_field("hit", 64'(want.hit), 64'(m_hit));
                    compare_field("via_gateway", 64'(want.via_gateway), 64'(m_via_gateway));
                    compare_field("mac_out", 64'(want.mac), 64'(m_mac_out));
                    compare_field("entry_index", 64'(want.index), 64'(m_entry_index));
                end
            end
            if (s_valid && s_ready) begin
                expected_answers.push_back(resolve_word(s_operation, s_ip_addr,
                                                        s_mac_addr, s_now_ms));
            end
        end
        outstanding = expected_answers.size();
    end

endmodule

// ===== sim/tb_arp_cache_lookup_update_top.sv =====
`timescale 1ns / 1ps

module tb_arp_cache_lookup_update_top;
    import arpc_pkg::*;

    localparam int SLOTS       = 4;
    localparam int PHASE_WORDS = 180;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 20;

    // Register index the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_operation;
    logic [IP_W-1:0]      s_ip_addr;
    logic [MAC_W-1:0]     s_mac_addr;
    logic [TIME_W-1:0]    s_now_ms;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_hit;
    logic                 m_via_gateway;
    logic [MAC_W-1:0]     m_mac_out;
    logic [IDX_OUT_W-1:0] m_entry_index;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [IP_W-1:0]      cfg_data;

    int mismatches;
    int outstanding;

    bit idle_enable;
    bit hold_request;

    // Current register values, used to aim addresses at the subnet and gateway
    logic [IP_W-1:0]   cur_local;
    logic [IP_W-1:0]   cur_mask;
    logic [IP_W-1:0]   cur_gateway;
    logic [TIME_W-1:0] clock_ms;

    arp_cache_lookup_update_top #(
        .ENTRIES(SLOTS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_ip_addr     (s_ip_addr),
        .s_mac_addr    (s_mac_addr),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_via_gateway (m_via_gateway),
        .m_mac_out     (m_mac_out),
        .m_entry_index (m_entry_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    arp_cache_checker #(
        .SLOTS(SLOTS)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_ip_addr     (s_ip_addr),
        .s_mac_addr    (s_mac_addr),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_via_gateway (m_via_gateway),
        .m_mac_out     (m_mac_out),
        .m_entry_index (m_entry_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("arp_cache_lookup_update_top verification failed");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                m_ready <= !(idle_enable && $urandom_range(0, 99) < 12);
            end
        end
    end

    // Offer one input word and hold it until accepted
    task automatic send_word(logic op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                             logic [TIME_W-1:0] now);
        @(negedge aclk);
        while (idle_enable && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_ip_addr   <= ip;
        s_mac_addr  <= mac;
        s_now_ms    <= now;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every result word is back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [IP_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LOCAL_IP:    cur_local   = value;
            REG_SUBNET_MASK: cur_mask    = value;
            REG_GATEWAY_IP:  cur_gateway = value;
            default: ;
        endcase
    endtask

    function automatic logic [IP_W-1:0] pick_address();
        case ($urandom_range(0, 9))
            0:       return cur_gateway;
            1, 2, 3: return (cur_local & cur_mask) | (32'($urandom_range(0, 3)) & ~cur_mask);
            4, 5:    return 32'h0A00_0000 | 32'($urandom_range(0, 3));
            6:       return '0;
            default: return 32'($urandom);
        endcase
    endfunction

    // Mostly small steps and ties, now and then a jump that wraps the ages
    function automatic logic [TIME_W-1:0] advance_clock();
        case ($urandom_range(0, 19))
            0:       clock_ms = 32'($urandom);
            1:       clock_ms = clock_ms - 32'($urandom_range(1, 1000));
            2:       clock_ms = '1;
            default: clock_ms = clock_ms + 32'($urandom_range(0, 3));
        endcase
        return clock_ms;
    endfunction

    task automatic run_random(int count, bit with_hold);
        logic [MAC_W-1:0] mac;
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 3) begin
                hold_request = 1'b1;
            end
            mac = {16'($urandom_range(0, 65535)), 32'($urandom)};
            send_word(1'($urandom_range(0, 1)), pick_address(), mac, advance_clock());
        end
        drain_results();
    endtask

    // Stimulus
    initial begin
        logic [IP_W-1:0] mask;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = OP_ENTER;
        s_ip_addr    = '0;
        s_mac_addr   = '0;
        s_now_ms     = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_LOCAL_IP;
        cfg_data     = '0;
        idle_enable  = 1'b1;
        hold_request = 1'b0;
        cur_local    = LOCAL_IP_RST;
        cur_mask     = SUBNET_MASK_RST;
        cur_gateway  = GATEWAY_IP_RST;
        clock_ms     = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty slots, fills through zero IPs and wrapped ages,
        // hits, local misses and gateway fallback
        send_word(OP_FIND,  32'h0000_0000, '1, 32'h0);
        send_word(OP_ENTER, GATEWAY_IP_RST, 48'h0200_0000_0001, 32'h10);
        send_word(OP_ENTER, 32'h0000_0000, 48'h0200_0000_0002, 32'h20);
        send_word(OP_ENTER, 32'hC0A8_5014, 48'h0200_0000_0003, 32'h30);
        send_word(OP_ENTER, 32'h0808_0808, 48'h0200_0000_0004, 32'hFFFF_FFFF);
        send_word(OP_ENTER, 32'hC0A8_5014, '1, 32'h40);
        send_word(OP_FIND,  32'hC0A8_5014, 48'h1234_5678_9ABC, 32'h40);
        send_word(OP_FIND,  32'hC0A8_5063, '0, 32'h40);
        send_word(OP_FIND,  32'h0808_0808, '0, 32'h40);
        send_word(OP_FIND,  32'h0102_0304, '0, 32'h40);
        send_word(OP_FIND,  32'hFFFF_FFFF, '1, 32'h40);
        send_word(OP_ENTER, 32'hFFFF_FFFF, '0, 32'h40);
        send_word(OP_ENTER, GATEWAY_IP_RST, 48'hA5A5_5A5A_A5A5, 32'h50);
        send_word(OP_ENTER, 32'hC0A8_5002, 48'h5A5A_A5A5_5A5A, 32'h50);
        send_word(OP_FIND,  32'h0000_0000, '0, 32'h50);
        send_word(OP_ENTER, 32'hC0A8_5003, 48'h8000_0000_0001, 32'h50);
        send_word(OP_FIND,  GATEWAY_IP_RST, '0, 32'h60);
        send_word(OP_FIND,  32'hC0A8_5003, '0, 32'h60);
        drain_results();

        // Reset register values, with a long result hold-off
        run_random(PHASE_WORDS, 1'b1);

        // Random prefix mask and gateway, no idling on either side
        idle_enable = 1'b0;
        mask = ~32'h0 << $urandom_range(0, 32);
        write_register(REG_LOCAL_IP, 32'($urandom));
        write_register(REG_SUBNET_MASK, mask);
        write_register(REG_GATEWAY_IP, 32'($urandom));
        run_random(PHASE_WORDS, 1'b0);
        idle_enable = 1'b1;

        // All zero: every address is local, no gateway fallback
        write_register(REG_LOCAL_IP, '0);
        write_register(REG_SUBNET_MASK, '0);
        write_register(REG_GATEWAY_IP, '0);
        run_random(PHASE_WORDS, 1'b0);

        // All ones: only the own address is local; ignored index written
        write_register(REG_LOCAL_IP, '1);
        write_register(REG_SUBNET_MASK, '1);
        write_register(REG_UNUSED, 32'($urandom));
        write_register(REG_GATEWAY_IP, '1);
        run_random(PHASE_WORDS, 1'b1);

        // Back to a /24 with an off-subnet gateway
        write_register(REG_LOCAL_IP, LOCAL_IP_RST);
        write_register(REG_SUBNET_MASK, SUBNET_MASK_RST);
        write_register(REG_GATEWAY_IP, 32'h0A00_0002);
        write_register(REG_UNUSED, '0);
        run_random(PHASE_WORDS, 1'b0);

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("arp_cache_lookup_update_top verification clean");
        end else begin
            $display("arp_cache_lookup_update_top verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/arpc_pkg.sv
sv/arpc_ram.sv
sv/arpc_match_unit.sv
sv/arp_cache_lookup_update_top.sv
sim/arp_cache_checker.sv
sim/tb_arp_cache_lookup_update_top.sv
